// ----- hdl/vapor_pressure_deficit_unit_assert.svh -----
// Assertion macros for the vapor pressure deficit unit.
// Used by the top level only; no other dependencies.
`ifndef VAPOR_PRESSURE_DEFICIT_UNIT_ASSERT_SVH
`define VAPOR_PRESSURE_DEFICIT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define VPD_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VPD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VPD_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg)
`define VPD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/vpd_pkg.sv -----
// Shared widths, fixed-point constants, codes and the 2^(i/16) table
// for the vapor pressure deficit unit. No dependencies.
`timescale 1ns / 1ps
package vpd_pkg;

	// field widths
	localparam int TEMP_W     = 14;
	localparam int RH_W       = 10;
	localparam int PA_W       = 16;
	localparam int DEF_W      = 17;
	localparam int BAND_W     = 3;
	localparam int OFS_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 104;

	// exponent datapath widths
	localparam int MAG_W  = 24;   // |1727*t|
	localparam int DEN_W  = 22;   // 100*(t+23730)
	localparam int PROD_W = 55;   // |num| * log2(e)
	localparam int DVD_W  = 42;   // rounded dividend
	localparam int DIV_QW = 21;   // quotient bits, one per divider stage
	localparam int SVP_LAT = 13 + DIV_QW;

	// fixed-point constants
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'd1073741824;
	localparam logic [18:0] RECIP6    = 19'd349526;      // ceil(2^21/6)
	localparam logic [19:0] RECIP10   = 20'd838861;      // ceil(2^23/10)
	localparam logic [27:0] RECIP1000 = 28'd137438954;   // ceil(2^37/1000)
	localparam logic [12:0] SVP_SCALE = 13'd6108;

	localparam logic signed [TEMP_W-1:0] LEAF_MIN = -14'sd4000;
	localparam logic signed [TEMP_W-1:0] LEAF_MAX = 14'sd8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEAF_OFFSET = 3'd0,
		CFG_BAND_LOW    = 3'd1,
		CFG_BAND_PROP   = 3'd2,
		CFG_BAND_VEG    = 3'd3,
		CFG_BAND_FLOWER = 3'd4
	} cfg_idx_t;

	typedef enum logic [BAND_W-1:0] {
		BAND_LOW    = 3'd0,
		BAND_PROP   = 3'd1,
		BAND_VEG    = 3'd2,
		BAND_FLOWER = 3'd3,
		BAND_HIGH   = 3'd4
	} band_t;

	// 2^(i/16) in Q30
	function automatic logic [30:0] pow2_frac(input logic [3:0] idx);
		logic [30:0] v;
		unique case (idx)
			4'd0:    v = 31'd1073741824;
			4'd1:    v = 31'd1121280435;
			4'd2:    v = 31'd1170923762;
			4'd3:    v = 31'd1222764986;
			4'd4:    v = 31'd1276901417;
			4'd5:    v = 31'd1333434672;
			4'd6:    v = 31'd1392470869;
			4'd7:    v = 31'd1454120821;
			4'd8:    v = 31'd1518500250;
			4'd9:    v = 31'd1585730000;
			4'd10:   v = 31'd1655936264;
			4'd11:   v = 31'd1729250827;
			4'd12:   v = 31'd1805811302;
			4'd13:   v = 31'd1885761398;
			4'd14:   v = 31'd1969251187;
			default: v = 31'd2056437386;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/vpd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vpd_pkg.
`timescale 1ns / 1ps
module vpd_div (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [vpd_pkg::DVD_W-1:0]  dividend,
	input  logic [vpd_pkg::DEN_W-1:0]  divisor,
	input  logic                       neg,
	output logic [vpd_pkg::DIV_QW-1:0] quotient,
	output logic                       quot_neg
);

	logic [vpd_pkg::DEN_W-1:0]  rem_s [vpd_pkg::DIV_QW];
	logic [vpd_pkg::DIV_QW-1:0] acc_s [vpd_pkg::DIV_QW];
	logic [vpd_pkg::DEN_W-1:0]  den_s [vpd_pkg::DIV_QW];
	logic                       neg_s [vpd_pkg::DIV_QW];

	for (genvar j = 0; j < vpd_pkg::DIV_QW; j++) begin : g_stage
		logic [vpd_pkg::DEN_W-1:0]  rem_in;
		logic [vpd_pkg::DIV_QW-1:0] acc_in;
		logic [vpd_pkg::DEN_W-1:0]  den_in;
		logic                       neg_in;
		logic [vpd_pkg::DEN_W:0]    trial;
		logic [vpd_pkg::DEN_W:0]    diff;
		logic                       qb;

		if (j == 0) begin : g_first
			assign rem_in = vpd_pkg::DEN_W'(dividend[vpd_pkg::DVD_W-1:vpd_pkg::DIV_QW]);
			assign acc_in = dividend[vpd_pkg::DIV_QW-1:0];
			assign den_in = divisor;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign acc_in = acc_s[j-1];
			assign den_in = den_s[j-1];
			assign neg_in = neg_s[j-1];
		end

		// bring down the next dividend bit, subtract if it fits
		assign trial = {rem_in, acc_in[vpd_pkg::DIV_QW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign qb    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= qb ? diff[vpd_pkg::DEN_W-1:0] : trial[vpd_pkg::DEN_W-1:0];
				acc_s[j] <= {acc_in[vpd_pkg::DIV_QW-2:0], qb};
				den_s[j] <= den_in;
				neg_s[j] <= neg_in;
			end
		end
	end

	assign quotient = acc_s[vpd_pkg::DIV_QW-1];
	assign quot_neg = neg_s[vpd_pkg::DIV_QW-1];

endmodule

// ----- hdl/vpd_svp.sv -----
// Tetens saturation vapor pressure pipeline: exponent by division,
// then 2^x by table and cubic series, scaled and rounded to Pa.
// Depends on vpd_pkg and vpd_div.
`timescale 1ns / 1ps
module vpd_svp (
	input  logic                              clk,
	input  logic                              adv,
	input  logic signed [vpd_pkg::TEMP_W-1:0] temp,
	output logic [vpd_pkg::PA_W-1:0]          svp
);

	// stage 1: |1727*t|, 100*(t+23730), sign
	logic [vpd_pkg::TEMP_W-1:0]  abs_t;
	logic signed [15:0]          t_sum;
	logic [vpd_pkg::MAG_W-1:0]   mag_s1;
	logic [vpd_pkg::DEN_W-1:0]   den_s1;
	logic                        neg_s1;

	assign abs_t = temp[vpd_pkg::TEMP_W-1] ? vpd_pkg::TEMP_W'(-temp) : vpd_pkg::TEMP_W'(temp);
	assign t_sum = 16'(temp) + 16'sd23730;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= vpd_pkg::MAG_W'(vpd_pkg::MAG_W'(abs_t) * vpd_pkg::MAG_W'(1727));
			den_s1 <= vpd_pkg::DEN_W'(vpd_pkg::DEN_W'(t_sum[14:0]) * vpd_pkg::DEN_W'(100));
			neg_s1 <= temp[vpd_pkg::TEMP_W-1];
		end
	end

	// stage 2: times log2(e)
	logic [vpd_pkg::PROD_W-1:0] prod_s2;
	logic [vpd_pkg::DEN_W-1:0]  den_s2;
	logic                       neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= vpd_pkg::PROD_W'(mag_s1) * vpd_pkg::PROD_W'(vpd_pkg::LOG2E_Q30);
			den_s2  <= den_s1;
			neg_s2  <= neg_s1;
		end
	end

	// stage 3: add half divisor, drop the 2^14 scale of the divisor
	logic [vpd_pkg::PROD_W:0]  rnd_sum;
	logic [vpd_pkg::DVD_W-1:0] dvd_s3;
	logic [vpd_pkg::DEN_W-1:0] den_s3;
	logic                      neg_s3;

	assign rnd_sum = {1'b0, prod_s2} + ((vpd_pkg::PROD_W+1)'(den_s2) << 13);

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s3 <= rnd_sum[vpd_pkg::PROD_W:14];
			den_s3 <= den_s2;
			neg_s3 <= neg_s2;
		end
	end

	// exponent quotient
	logic [vpd_pkg::DIV_QW-1:0] quot;
	logic                       quot_neg;

	vpd_div u_div (
		.clk      (clk),
		.adv      (adv),
		.dividend (dvd_s3),
		.divisor  (den_s3),
		.neg      (neg_s3),
		.quotient (quot),
		.quot_neg (quot_neg)
	);

	// stage 4: signed exponent y in Q16
	localparam int Y_W = vpd_pkg::DIV_QW + 1;
	localparam int K_W = Y_W - 16;
	logic signed [Y_W-1:0] y_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s4 <= quot_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		end
	end

	// stage 5: k = floor(y), table index, u = r*ln2
	logic [41:0]           u_full;
	logic [25:0]           u_s5;
	logic [3:0]            idx_s5;
	logic signed [K_W-1:0] k_s5;

	assign u_full = 42'(y_s4[11:0]) * 42'(vpd_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s5   <= u_full[41:16];
			idx_s5 <= y_s4[15:12];
			k_s5   <= y_s4[Y_W-1:16];
		end
	end

	// stage 6: u^2
	logic [51:0]           u2_full;
	logic [21:0]           u2_s6;
	logic [25:0]           u_s6;
	logic [3:0]            idx_s6;
	logic signed [K_W-1:0] k_s6;

	assign u2_full = 52'(u_s5) * 52'(u_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			u2_s6  <= u2_full[51:30];
			u_s6   <= u_s5;
			idx_s6 <= idx_s5;
			k_s6   <= k_s5;
		end
	end

	// stage 7: u^3
	logic [47:0]           u3_full;
	logic [17:0]           u3_s7;
	logic [21:0]           u2_s7;
	logic [25:0]           u_s7;
	logic [3:0]            idx_s7;
	logic signed [K_W-1:0] k_s7;

	assign u3_full = 48'(u2_s6) * 48'(u_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			u3_s7  <= u3_full[47:30];
			u2_s7  <= u2_s6;
			u_s7   <= u_s6;
			idx_s7 <= idx_s6;
			k_s7   <= k_s6;
		end
	end

	// stage 8: u^3/6 by reciprocal
	logic [36:0]           d6_full;
	logic [15:0]           d6_s8;
	logic [21:0]           u2_s8;
	logic [25:0]           u_s8;
	logic [3:0]            idx_s8;
	logic signed [K_W-1:0] k_s8;

	assign d6_full = 37'(u3_s7) * 37'(vpd_pkg::RECIP6);

	always_ff @(posedge clk) begin
		if (adv) begin
			d6_s8  <= d6_full[36:21];
			u2_s8  <= u2_s7;
			u_s8   <= u_s7;
			idx_s8 <= idx_s7;
			k_s8   <= k_s7;
		end
	end

	// stage 9: series sum for 2^r
	logic [30:0]           p_s9;
	logic [3:0]            idx_s9;
	logic signed [K_W-1:0] k_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9   <= vpd_pkg::ONE_Q30 + 31'(u_s8) + 31'(u2_s8[21:1]) + 31'(d6_s8);
			idx_s9 <= idx_s8;
			k_s9   <= k_s8;
		end
	end

	// stage 10: mantissa = table * 2^r
	logic [61:0]           m_full;
	logic [30:0]           m_s10;
	logic signed [K_W-1:0] k_s10;

	assign m_full = 62'(vpd_pkg::pow2_frac(idx_s9)) * 62'(p_s9);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s10 <= m_full[60:30];
			k_s10 <= k_s9;
		end
	end

	// stage 11: scale by 610.8 (x10), shift count 30-k
	logic [43:0]     sc_s11;
	logic signed [6:0] sh_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s11 <= 44'(m_s10) * 44'(vpd_pkg::SVP_SCALE);
			sh_s11 <= 7'sd30 - 7'(k_s10);
		end
	end

	// stage 12: shift with rounding half, saturation test
	logic [44:0] w_full;
	logic [19:0] w_s12;
	logic        big_s12;

	assign w_full = 45'(sc_s11 >> sh_s11[5:0]) + 45'd5;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s12   <= w_full[19:0];
			big_s12 <= sh_s11[6] || (w_full >= 45'd655360);
		end
	end

	// stage 13: divide by ten, saturate
	logic [39:0]              q10_full;
	logic [vpd_pkg::PA_W-1:0] res_s13;

	assign q10_full = 40'(w_s12) * 40'(vpd_pkg::RECIP10);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s13 <= big_s12 ? '1 : q10_full[38:23];
		end
	end

	assign svp = res_s13;

endmodule

// ----- hdl/vapor_pressure_deficit_unit.sv -----
// Channel   Dir  Width  Fields (low bit up)
// s_axis    in   24     air_temp[13:0], rel_humidity[23:14]
// m_axis    out  104    svp_air, actual_vp, deficit_air, leaf_temp, svp_leaf,
//                       deficit_leaf, band_air, band_leaf, 2 pad bits
// cfg       in   3+16   register index, write data
//
// One item per cycle while the output is not stalled; the path holds a 21-stage
// exponent divider plus series, scaling, humidity and band stages. Both pressures
// run in parallel units. Reset clears valid bits and config registers to their
// defaults. An output stall freezes the whole pipeline; a one-item skid register
// accepts one more item while a result waits.
// Depends on vpd_pkg, vpd_svp, vpd_div and the assertion macro header.
`timescale 1ns / 1ps
`include "vapor_pressure_deficit_unit_assert.svh"
module vapor_pressure_deficit_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [vpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // air_temp, rel_humidity
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [vpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // svp_air, actual_vp,
	                                                         // deficit_air, leaf_temp, svp_leaf,
	                                                         // deficit_leaf, band_air, band_leaf
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LAT = vpd_pkg::SVP_LAT;
	localparam int TOT = LAT + 4;

	// configuration registers
	logic signed [vpd_pkg::OFS_W-1:0] leaf_offset_q;
	logic [15:0] band_low_q, band_prop_q, band_veg_q, band_flower_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_offset_q <= '0;
			band_low_q    <= 16'd400;
			band_prop_q   <= 16'd800;
			band_veg_q    <= 16'd1200;
			band_flower_q <= 16'd1600;
		end else if (cfg_valid) begin
			unique case (vpd_pkg::cfg_idx_t'(cfg_index))
				vpd_pkg::CFG_LEAF_OFFSET: leaf_offset_q <= cfg_data[vpd_pkg::OFS_W-1:0];
				vpd_pkg::CFG_BAND_LOW:    band_low_q    <= cfg_data;
				vpd_pkg::CFG_BAND_PROP:   band_prop_q   <= cfg_data;
				vpd_pkg::CFG_BAND_VEG:    band_veg_q    <= cfg_data;
				vpd_pkg::CFG_BAND_FLOWER: band_flower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the last stage is empty or being taken
	logic vld_s [TOT+1];
	logic adv;
	logic take_in;

	assign adv     = !vld_s[TOT] || m_axis_tready;
	assign take_in = s_axis_tvalid && s_axis_tready;

	// skid register for an item taken during a stall
	logic                                skid_vld_q;
	logic signed [vpd_pkg::TEMP_W-1:0]   skid_t_q;
	logic [vpd_pkg::RH_W-1:0]            skid_rh_q;

	assign s_axis_tready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			skid_vld_q <= 1'b0;
		end else if (take_in) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && take_in) begin
			skid_t_q  <= s_axis_tdata[vpd_pkg::TEMP_W-1:0];
			skid_rh_q <= s_axis_tdata[vpd_pkg::TEMP_W +: vpd_pkg::RH_W];
		end
	end

	// stage 1 source and leaf temperature
	logic signed [vpd_pkg::TEMP_W-1:0] src_t;
	logic [vpd_pkg::RH_W-1:0]          src_rh;
	logic signed [vpd_pkg::TEMP_W:0]   leaf_diff;
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_c;

	assign src_t  = skid_vld_q ? skid_t_q : s_axis_tdata[vpd_pkg::TEMP_W-1:0];
	assign src_rh = skid_vld_q ? skid_rh_q : s_axis_tdata[vpd_pkg::TEMP_W +: vpd_pkg::RH_W];
	assign leaf_diff = (vpd_pkg::TEMP_W+1)'(src_t) - (vpd_pkg::TEMP_W+1)'(leaf_offset_q);

	always_comb begin
		if (leaf_diff < (vpd_pkg::TEMP_W+1)'(vpd_pkg::LEAF_MIN)) begin
			leaf_c = vpd_pkg::LEAF_MIN;
		end else if (leaf_diff > (vpd_pkg::TEMP_W+1)'(vpd_pkg::LEAF_MAX)) begin
			leaf_c = vpd_pkg::LEAF_MAX;
		end else begin
			leaf_c = leaf_diff[vpd_pkg::TEMP_W-1:0];
		end
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= TOT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= skid_vld_q || take_in;
			for (int i = 1; i <= TOT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// stage 1 and delay lines alongside the pressure units
	logic signed [vpd_pkg::TEMP_W-1:0] t_s1;
	logic [vpd_pkg::RH_W-1:0]          rh_dly_s   [LAT+1];
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_dly_s [LAT+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1          <= src_t;
			rh_dly_s[0]   <= src_rh;
			leaf_dly_s[0] <= leaf_c;
			for (int i = 1; i <= LAT; i++) begin
				rh_dly_s[i]   <= rh_dly_s[i-1];
				leaf_dly_s[i] <= leaf_dly_s[i-1];
			end
		end
	end

	// saturation pressures
	logic [vpd_pkg::PA_W-1:0] svp_air_c, svp_leaf_c;

	vpd_svp u_svp_air (
		.clk  (clk),
		.adv  (adv),
		.temp (t_s1),
		.svp  (svp_air_c)
	);

	vpd_svp u_svp_leaf (
		.clk  (clk),
		.adv  (adv),
		.temp (leaf_dly_s[0]),
		.svp  (svp_leaf_c)
	);

	// stage 36: svp * rh + 500
	logic [25:0]                       x_s36;
	logic [vpd_pkg::PA_W-1:0]          sa_s36, sl_s36;
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_s36;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s36    <= 26'(svp_air_c) * 26'(rh_dly_s[LAT]) + 26'd500;
			sa_s36   <= svp_air_c;
			sl_s36   <= svp_leaf_c;
			leaf_s36 <= leaf_dly_s[LAT];
		end
	end

	// stage 37: divide by 1000, saturate
	logic [53:0]                       avp_full;
	logic [vpd_pkg::PA_W-1:0]          avp_s37, sa_s37, sl_s37;
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_s37;

	assign avp_full = 54'(x_s36) * 54'(vpd_pkg::RECIP1000);

	always_ff @(posedge clk) begin
		if (adv) begin
			avp_s37  <= avp_full[53] ? '1 : avp_full[52:37];
			sa_s37   <= sa_s36;
			sl_s37   <= sl_s36;
			leaf_s37 <= leaf_s36;
		end
	end

	// stage 38: deficits
	logic signed [vpd_pkg::DEF_W-1:0]  dair_s38, dleaf_s38;
	logic [vpd_pkg::PA_W-1:0]          avp_s38, sa_s38, sl_s38;
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_s38;

	always_ff @(posedge clk) begin
		if (adv) begin
			dair_s38  <= $signed({1'b0, sa_s37}) - $signed({1'b0, avp_s37});
			dleaf_s38 <= $signed({1'b0, sl_s37}) - $signed({1'b0, avp_s37});
			avp_s38   <= avp_s37;
			sa_s38    <= sa_s37;
			sl_s38    <= sl_s37;
			leaf_s38  <= leaf_s37;
		end
	end

	// band classification, tests in fixed order
	function automatic vpd_pkg::band_t band_of(input logic signed [vpd_pkg::DEF_W-1:0] d,
			input logic [15:0] lo, input logic [15:0] pr, input logic [15:0] vg,
			input logic [15:0] fl);
		vpd_pkg::band_t b;
		if (d < $signed({1'b0, lo})) begin
			b = vpd_pkg::BAND_LOW;
		end else if (d < $signed({1'b0, pr})) begin
			b = vpd_pkg::BAND_PROP;
		end else if (d < $signed({1'b0, vg})) begin
			b = vpd_pkg::BAND_VEG;
		end else if (d <= $signed({1'b0, fl})) begin
			b = vpd_pkg::BAND_FLOWER;
		end else begin
			b = vpd_pkg::BAND_HIGH;
		end
		return b;
	endfunction

	// stage 39: output register
	logic [vpd_pkg::PA_W-1:0]          sa_s39, avp_s39, sl_s39;
	logic signed [vpd_pkg::DEF_W-1:0]  dair_s39, dleaf_s39;
	logic signed [vpd_pkg::TEMP_W-1:0] leaf_s39;
	vpd_pkg::band_t                    band_air_s39, band_leaf_s39;

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s39        <= sa_s38;
			avp_s39       <= avp_s38;
			sl_s39        <= sl_s38;
			dair_s39      <= dair_s38;
			dleaf_s39     <= dleaf_s38;
			leaf_s39      <= leaf_s38;
			band_air_s39  <= band_of(dair_s38, band_low_q, band_prop_q, band_veg_q,
				band_flower_q);
			band_leaf_s39 <= band_of(dleaf_s38, band_low_q, band_prop_q, band_veg_q,
				band_flower_q);
		end
	end

	assign m_axis_tvalid = vld_s[TOT];
	assign m_axis_tdata  = {2'b00, band_leaf_s39, band_air_s39, dleaf_s39, sl_s39,
		leaf_s39, dair_s39, avp_s39, sa_s39};

	// checks
	`VPD_ASSERT_NEXT(a_skid_hold, clk, arst_n, skid_vld_q && !adv,
		skid_vld_q && $stable(skid_t_q) && $stable(skid_rh_q), "skid item lost during stall")
	`VPD_ASSERT_NEXT(a_skid_fill, clk, arst_n, take_in && !adv, skid_vld_q,
		"item taken in a stall not held in skid")
	`VPD_ASSERT_NOW(a_def_air, clk, arst_n, m_axis_tvalid,
		dair_s39 == ($signed({1'b0, sa_s39}) - $signed({1'b0, avp_s39})),
		"air deficit inconsistent with pressures")
	`VPD_ASSERT_NOW(a_leaf_rng, clk, arst_n, m_axis_tvalid,
		(leaf_s39 >= vpd_pkg::LEAF_MIN) && (leaf_s39 <= vpd_pkg::LEAF_MAX),
		"leaf temperature out of range")

endmodule
